// File: rtl/qct_pkg.sv
// Shared types and constants of the quad countdown timer.
package qct_pkg;

    localparam int NUM_TIMERS_DEF = 4;

    localparam int DATA_W = 32;
    localparam int CTRL_W = 8;
    localparam int PRESC_W = 8;
    localparam int IRQ_W = 4;

    // Control register bit positions.
    localparam int CTL_ENABLE_BIT = 7;
    localparam int CTL_PERIODIC_BIT = 6;
    localparam int CTL_INTEN_BIT = 5;
    localparam int CTL_PRESC_LSB = 2;
    localparam int CTL_SIZE32_BIT = 1;
    localparam int CTL_ONESHOT_BIT = 0;

    localparam logic [CTRL_W-1:0] CTL_RESET = 8'h20;
    localparam logic [DATA_W-1:0] WORD_MASK = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] HALF_MASK = 32'h0000_FFFF;

    localparam logic [PRESC_W-1:0] PRESC_LIM_16 = 8'd15;
    localparam logic [PRESC_W-1:0] PRESC_LIM_256 = 8'd255;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WRITE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        PRESC_DIV1  = 2'd0,
        PRESC_DIV16 = 2'd1
    } t_presc;

    typedef enum logic [2:0] {
        OFF_LOAD   = 3'd0,
        OFF_VALUE  = 3'd1,
        OFF_CTRL   = 3'd2,
        OFF_INTCLR = 3'd3,
        OFF_RAW    = 3'd4,
        OFF_MASKED = 3'd5,
        OFF_BGLOAD = 3'd6
    } t_reg_off;

endpackage

// File: rtl/qct_if.sv
// Valid/ready channels for request beats and result beats of the timer.
interface qct_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [1:0]  timer_sel;
    logic [2:0]  reg_offset;
    logic [31:0] write_data;

    modport source (output valid, action, timer_sel, reg_offset, write_data, input ready);
    modport sink (input valid, action, timer_sel, reg_offset, write_data, output ready);
endinterface

interface qct_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [3:0]  irq_lines;

    modport source (output valid, read_data, irq_lines, input ready);
    modport sink (input valid, read_data, irq_lines, output ready);
endinterface

// File: rtl/quad_countdown_timer_core.sv
// Top level of the quad countdown timer: timer state, register access and result register.
//
// Four down-counting timers with a word register bank each (load, value, control, interrupt
// clear, raw and masked status, background load). Every request beat is a timer clock tick,
// a register read or a register write, and produces exactly one result beat carrying the
// read data (zero unless it is a read of a readable register) and the masked interrupt of
// each timer after the beat. The state update and the result are computed in the cycle of
// acceptance and the result is held in a single output register, so a new beat is taken
// every cycle as long as the result side keeps draining. Reset needs no clearing pass.
module quad_countdown_timer_core #(
    parameter int NUM_TIMERS = qct_pkg::NUM_TIMERS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qct_in_if.sink     i_in,
    qct_out_if.source  o_out
);
    import qct_pkg::*;

    logic [DATA_W-1:0]  r_reload [NUM_TIMERS];
    logic [DATA_W-1:0]  r_count  [NUM_TIMERS];
    logic [CTRL_W-1:0]  r_ctrl   [NUM_TIMERS];
    logic               r_raw    [NUM_TIMERS];
    logic [PRESC_W-1:0] r_presc  [NUM_TIMERS];

    logic [DATA_W-1:0]  n_reload [NUM_TIMERS];
    logic [DATA_W-1:0]  n_count  [NUM_TIMERS];
    logic [CTRL_W-1:0]  n_ctrl   [NUM_TIMERS];
    logic               n_raw    [NUM_TIMERS];
    logic [PRESC_W-1:0] n_presc  [NUM_TIMERS];

    logic               r_out_valid;
    logic [DATA_W-1:0]  r_rd;
    logic [IRQ_W-1:0]   r_irq;
    logic [DATA_W-1:0]  n_rd;
    logic [IRQ_W-1:0]   n_irq;

    logic               accept;
    t_action            action;
    t_reg_off           offset;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign action     = t_action'(i_in.action);
    assign offset     = t_reg_off'(i_in.reg_offset);

    always_comb begin
        logic [DATA_W-1:0]  mask;
        logic [DATA_W-1:0]  cur;
        logic [DATA_W-1:0]  nxt;
        logic [PRESC_W-1:0] limit;
        logic               sel_hit;

        n_rd  = '0;
        n_irq = '0;
        for (int t = 0; t < NUM_TIMERS; t++) begin
            n_reload[t] = r_reload[t];
            n_count[t]  = r_count[t];
            n_ctrl[t]   = r_ctrl[t];
            n_raw[t]    = r_raw[t];
            n_presc[t]  = r_presc[t];

            mask    = r_ctrl[t][CTL_SIZE32_BIT] ? WORD_MASK : HALF_MASK;
            cur     = r_count[t] & mask;
            sel_hit = (i_in.timer_sel == 2'(t));

            case (t_presc'(r_ctrl[t][CTL_PRESC_LSB +: 2]))
                PRESC_DIV1:  limit = '0;
                PRESC_DIV16: limit = PRESC_LIM_16;
                default:     limit = PRESC_LIM_256;
            endcase

            // A zero count in one-shot mode stays put and raises nothing.
            if (cur == '0) begin
                if (r_ctrl[t][CTL_ONESHOT_BIT]) begin
                    nxt = '0;
                end else if (r_ctrl[t][CTL_PERIODIC_BIT]) begin
                    nxt = r_reload[t] & mask;
                end else begin
                    nxt = mask;
                end
            end else begin
                nxt = cur - 1'b1;
            end

            if (action == ACT_READ && sel_hit) begin
                case (offset)
                    OFF_LOAD, OFF_BGLOAD: n_rd = r_reload[t];
                    OFF_VALUE:            n_rd = cur;
                    OFF_CTRL:             n_rd = DATA_W'(r_ctrl[t]);
                    OFF_RAW:              n_rd = DATA_W'(r_raw[t]);
                    OFF_MASKED:           n_rd = DATA_W'(r_raw[t] & r_ctrl[t][CTL_INTEN_BIT]);
                    default:              n_rd = '0;
                endcase
            end

            if (accept && action == ACT_TICK && r_ctrl[t][CTL_ENABLE_BIT]) begin
                if (r_presc[t] >= limit) begin
                    n_presc[t] = '0;
                    n_count[t] = nxt;
                    if (nxt == '0 && !(cur == '0 && r_ctrl[t][CTL_ONESHOT_BIT])) begin
                        n_raw[t] = 1'b1;
                    end
                end else begin
                    n_presc[t] = r_presc[t] + 1'b1;
                end
            end

            if (accept && action == ACT_WRITE && sel_hit) begin
                case (offset)
                    OFF_LOAD: begin
                        n_reload[t] = i_in.write_data;
                        n_count[t]  = i_in.write_data;
                        n_presc[t]  = '0;
                    end
                    OFF_CTRL: begin
                        n_ctrl[t]  = i_in.write_data[CTRL_W-1:0];
                        n_presc[t] = '0;
                    end
                    OFF_INTCLR: n_raw[t]    = 1'b0;
                    OFF_BGLOAD: n_reload[t] = i_in.write_data;
                    default: ;
                endcase
            end

            n_irq[t] = n_raw[t] & n_ctrl[t][CTL_INTEN_BIT];
        end
        if (action != ACT_READ) begin
            n_rd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_TIMERS; t++) begin
                r_reload[t] <= '0;
                r_count[t]  <= WORD_MASK;
                r_ctrl[t]   <= CTL_RESET;
                r_raw[t]    <= 1'b0;
                r_presc[t]  <= '0;
            end
        end else begin
            for (int t = 0; t < NUM_TIMERS; t++) begin
                r_reload[t] <= n_reload[t];
                r_count[t]  <= n_count[t];
                r_ctrl[t]   <= n_ctrl[t];
                r_raw[t]    <= n_raw[t];
                r_presc[t]  <= n_presc[t];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_out_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd  <= n_rd;
            r_irq <= n_irq;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_rd;
    assign o_out.irq_lines = r_irq;

endmodule

// File: rtl/qct_checker.sv
// Port-level checks of the quad countdown timer and their binding to the top level.
module qct_checker #(
    parameter int NUM_TIMERS = qct_pkg::NUM_TIMERS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_in_action,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_read_data,
    input logic [3:0]  i_out_irq_lines
);
    import qct_pkg::*;

    // A result beat that is not taken keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_read_data)
            && $stable(i_out_irq_lines))
        else $error("stalled result beat changed");

    // Every accepted request beat shows up as a result beat in the next cycle.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("accepted beat produced no result");

    // An empty result register never holds back the request side.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("request side stalled with empty output");

    // Only reads return data.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_action != ACT_READ |=> i_out_read_data == '0)
        else $error("nonzero data on a tick or write");

    // Interrupt lines of absent timers stay low.
    a_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_irq_lines >> NUM_TIMERS) == 4'd0)
        else $error("interrupt raised by an absent timer");

endmodule

bind quad_countdown_timer_core qct_checker #(
    .NUM_TIMERS(NUM_TIMERS)
) u_qct_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_in_action     (i_in.action),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_read_data (o_out.read_data),
    .i_out_irq_lines (o_out.irq_lines)
);
